// ----- sv/cascaded_third_order_iir_lowpass_macros.svh -----
// assertion macros used by the lowpass filter engine module
// expects clk and rst_n in the scope of each use
`ifndef CASCADED_THIRD_ORDER_IIR_LOWPASS_MACROS_SVH
`define CASCADED_THIRD_ORDER_IIR_LOWPASS_MACROS_SVH

// same-cycle implication, disabled in reset
`define C3IIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define C3IIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/c3iir_pkg.sv -----
// package for the cascaded third-order iir lowpass filter
// widths, fixed-point coefficients, types and the distributed-arithmetic term function
// no dependencies
package c3iir_pkg;

  localparam int STATE_W     = 56;
  localparam int FRAC_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_SHIFT  = 30;
  localparam int RECIP_SHIFT = 50;

  localparam int SHIFT_IN  = RECIP_SHIFT - FRAC_W;
  localparam int SHIFT_SEC = COEF_SHIFT;
  localparam int SHIFT_MID = RECIP_SHIFT;

  localparam int DA_OPS = 7;
  localparam int CNT_W  = $clog2(STATE_W);
  localparam int DA_TW  = 37;
  localparam int DA_PW  = 38;
  localparam int SUM_W  = DA_PW + 1;
  localparam int RES_W  = DA_PW + STATE_W;
  localparam int RND_W  = STATE_W - FRAC_W + 1;

  localparam int OP_X0 = 0;
  localparam int OP_X1 = 1;
  localparam int OP_X2 = 2;
  localparam int OP_X3 = 3;
  localparam int OP_Y0 = 4;
  localparam int OP_Y1 = 5;
  localparam int OP_Y2 = 6;

  localparam logic [63:0] C0_U =
    (64'd9376118463 * 64'd1048576 + 64'd4882812) / 64'd9765625;
  localparam logic [63:0] C1_U =
    (64'd28735581964 * 64'd1048576 + 64'd4882812) / 64'd9765625;
  localparam logic [63:0] C2_U =
    (64'd29359283717 * 64'd1048576 + 64'd4882812) / 64'd9765625;
  localparam logic [63:0] RECIP_NUM = (64'd10000 << RECIP_SHIFT) + 64'd2224887836;
  localparam logic [63:0] RECIP_U   = RECIP_NUM / 64'd4449775673;
  localparam logic [63:0] UNIT_U    = 64'd1 << COEF_SHIFT;
  localparam logic [63:0] TRIPLE_U  = 64'd3 << COEF_SHIFT;

  localparam logic [DA_TW-1:0]        C1_MAG      = C1_U[DA_TW-1:0];
  localparam logic signed [DA_TW-1:0] COEF_C0     = C0_U[DA_TW-1:0];
  localparam logic signed [DA_TW-1:0] COEF_C1     = -C1_MAG;
  localparam logic signed [DA_TW-1:0] COEF_C2     = C2_U[DA_TW-1:0];
  localparam logic signed [DA_TW-1:0] COEF_UNIT   = UNIT_U[DA_TW-1:0];
  localparam logic signed [DA_TW-1:0] COEF_TRIPLE = TRIPLE_U[DA_TW-1:0];
  localparam logic signed [DA_TW-1:0] GAIN_RECIP  = RECIP_U[DA_TW-1:0];

  typedef logic signed [STATE_W-1:0] st_word_t;
  typedef logic [DA_OPS-1:0][STATE_W-1:0] da_ops_t;
  typedef logic [2:0][STATE_W-1:0] hist_t;

  typedef enum logic [1:0] {
    MODE_SCALE_IN,
    MODE_SEC,
    MODE_SCALE_MID
  } da_mode_t;

  typedef struct packed {
    logic     start;
    da_mode_t mode;
  } da_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_IN,
    ST_SEC1,
    ST_SCALE_MID,
    ST_SEC2,
    ST_DONE
  } seq_state_t;

  // weighted sum of coefficients with operand bit set; scale modes: GAIN_RECIP if x3
  function automatic logic signed [DA_TW-1:0] da_term(input da_mode_t mode,
                                                      input logic [DA_OPS-1:0] bits);
    logic signed [DA_TW-1:0] t;
    t = '0;
    if (mode == MODE_SEC) begin
      if (bits[OP_X0]) t = t + COEF_UNIT;
      if (bits[OP_X1]) t = t + COEF_TRIPLE;
      if (bits[OP_X2]) t = t + COEF_TRIPLE;
      if (bits[OP_X3]) t = t + COEF_UNIT;
      if (bits[OP_Y0]) t = t + COEF_C0;
      if (bits[OP_Y1]) t = t + COEF_C1;
      if (bits[OP_Y2]) t = t + COEF_C2;
    end else if (bits[OP_X3]) begin
      t = GAIN_RECIP;
    end
    return t;
  endfunction

  function automatic logic [CNT_W-1:0] rnd_shift(input da_mode_t mode);
    logic [CNT_W-1:0] n;
    unique case (mode)
      MODE_SCALE_IN:  n = CNT_W'(SHIFT_IN);
      MODE_SCALE_MID: n = CNT_W'(SHIFT_MID);
      default:        n = CNT_W'(SHIFT_SEC);
    endcase
    return n;
  endfunction

endpackage

// ----- sv/c3iir_da.sv -----
// bit-serial distributed-arithmetic inner product engine
// seven operands shifted lsb first, rounded rescale and saturation at the end
// depends on c3iir_pkg and the assertion macro header
`include "cascaded_third_order_iir_lowpass_macros.svh"

module c3iir_da (
  input  logic                clk,
  input  logic                rst_n,
  input  c3iir_pkg::da_cmd_t  cmd,
  input  c3iir_pkg::da_ops_t  ops,
  output c3iir_pkg::st_word_t res,
  output logic                done
);
  import c3iir_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  da_mode_t                mode_r, mode_nxt;
  da_ops_t                 opsr_r, opsr_nxt;
  logic signed [DA_PW-1:0] p_r, p_nxt;
  logic [STATE_W-1:0]      low_r, low_nxt;
  st_word_t                res_r, res_nxt;

  logic [DA_OPS-1:0]       tap;
  logic signed [DA_TW-1:0] term;
  logic [DA_TW-1:0]        addend;
  logic                    is_last;
  logic                    rnd_in;
  logic [CNT_W-1:0]        shift_n;
  logic signed [SUM_W-1:0] sum;
  logic signed [DA_PW-1:0] p_step;
  logic [STATE_W-1:0]      low_step;
  logic signed [RES_W-1:0] full;
  logic signed [RES_W-1:0] shifted;
  logic [RES_W-STATE_W:0]  upper;
  st_word_t                sat_val;

  always_comb begin
    for (int k = 0; k < DA_OPS; k++) begin
      tap[k] = opsr_r[k][0];
    end
    term     = da_term(mode_r, tap);
    is_last  = (cnt_r == CNT_W'(STATE_W - 1));
    shift_n  = rnd_shift(mode_r);
    rnd_in   = (cnt_r == shift_n - 1'b1);
    // sign bit of every operand carries negative weight
    addend   = is_last ? ~term : term;
    sum      = SUM_W'(p_r) + {{(SUM_W-DA_TW){addend[DA_TW-1]}}, addend}
             + SUM_W'(is_last) + SUM_W'(rnd_in);
    p_step   = sum[SUM_W-1:1];
    low_step = {sum[0], low_r[STATE_W-1:1]};
    full     = {p_step, low_step};
    shifted  = full >>> shift_n;
    upper    = shifted[RES_W-1:STATE_W-1];
    if ((&upper) || !(|upper)) begin
      sat_val = shifted[STATE_W-1:0];
    end else if (shifted[RES_W-1]) begin
      sat_val = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    opsr_nxt = opsr_r;
    p_nxt    = p_r;
    low_nxt  = low_r;
    res_nxt  = res_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mode_nxt = cmd.mode;
      opsr_nxt = ops;
      p_nxt    = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      p_nxt   = p_step;
      low_nxt = low_step;
      for (int k = 0; k < DA_OPS; k++) begin
        opsr_nxt[k] = {1'b0, opsr_r[k][STATE_W-1:1]};
      end
      if (is_last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= MODE_SEC;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opsr_r <= opsr_nxt;
    p_r    <= p_nxt;
    low_r  <= low_nxt;
    res_r  <= res_nxt;
  end

  assign res  = res_r;
  assign done = done_r;

  `C3IIR_ASSERT_IMP(a_start_idle, cmd.start, !busy_r, "engine started while busy")
  `C3IIR_ASSERT_NXT(a_last_done, busy_r && is_last && !cmd.start, done_r && !busy_r, "pass did not end after the sign bit")
  `C3IIR_ASSERT_IMP(a_done_after_run, done_r, $past(busy_r) && !busy_r, "done without a pass")

endmodule

// ----- sv/c3iir_seq.sv -----
// sequencer for the two filter sections and the gain scaling passes
// holds input and output histories, drives the bit-serial engine
// depends on c3iir_pkg and c3iir_da
module c3iir_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic signed [c3iir_pkg::SAMPLE_W-1:0] sample,
  output logic                                ready,
  output logic                                res_valid,
  input  logic                                res_take,
  output c3iir_pkg::st_word_t                 y
);
  import c3iir_pkg::*;

  seq_state_t state_r, state_nxt;
  hist_t      xa_r, xa_nxt;
  hist_t      ya_r, ya_nxt;
  hist_t      xb_r, xb_nxt;
  hist_t      yb_r, yb_nxt;

  da_cmd_t    cmd;
  da_ops_t    ops;
  st_word_t   da_res;
  logic       da_done;

  c3iir_da u_da (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .ops  (ops),
    .res  (da_res),
    .done (da_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (go) state_nxt = ST_SCALE_IN;
      ST_SCALE_IN:  if (da_done) state_nxt = ST_SEC1;
      ST_SEC1:      if (da_done) state_nxt = ST_SCALE_MID;
      ST_SCALE_MID: if (da_done) state_nxt = ST_SEC2;
      ST_SEC2:      if (da_done) state_nxt = ST_DONE;
      ST_DONE:      if (res_take) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.mode  = MODE_SEC;
    ops       = '0;
    ready     = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ready = 1'b1;
        if (go) begin
          cmd.start  = 1'b1;
          cmd.mode   = MODE_SCALE_IN;
          ops[OP_X3] = {{(STATE_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        end
      end
      ST_SCALE_IN: begin
        if (da_done) begin
          cmd.start  = 1'b1;
          cmd.mode   = MODE_SEC;
          ops[OP_X0] = xa_r[0];
          ops[OP_X1] = xa_r[1];
          ops[OP_X2] = xa_r[2];
          ops[OP_X3] = da_res;
          ops[OP_Y0] = ya_r[0];
          ops[OP_Y1] = ya_r[1];
          ops[OP_Y2] = ya_r[2];
        end
      end
      ST_SEC1: begin
        if (da_done) begin
          cmd.start  = 1'b1;
          cmd.mode   = MODE_SCALE_MID;
          ops[OP_X3] = da_res;
        end
      end
      ST_SCALE_MID: begin
        if (da_done) begin
          cmd.start  = 1'b1;
          cmd.mode   = MODE_SEC;
          ops[OP_X0] = xb_r[0];
          ops[OP_X1] = xb_r[1];
          ops[OP_X2] = xb_r[2];
          ops[OP_X3] = da_res;
          ops[OP_Y0] = yb_r[0];
          ops[OP_Y1] = yb_r[1];
          ops[OP_Y2] = yb_r[2];
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // histories shift as each pass result lands, index 0 oldest
  always_comb begin
    xa_nxt = xa_r;
    ya_nxt = ya_r;
    xb_nxt = xb_r;
    yb_nxt = yb_r;
    if (da_done) begin
      unique case (state_r)
        ST_SCALE_IN:  xa_nxt = {da_res, xa_r[2], xa_r[1]};
        ST_SEC1:      ya_nxt = {da_res, ya_r[2], ya_r[1]};
        ST_SCALE_MID: xb_nxt = {da_res, xb_r[2], xb_r[1]};
        ST_SEC2:      yb_nxt = {da_res, yb_r[2], yb_r[1]};
        default:      xa_nxt = xa_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      xa_r    <= '0;
      ya_r    <= '0;
      xb_r    <= '0;
      yb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      xa_r    <= xa_nxt;
      ya_r    <= ya_nxt;
      xb_r    <= xb_nxt;
      yb_r    <= yb_nxt;
    end
  end

  assign y = da_res;

endmodule

// ----- sv/cascaded_third_order_iir_lowpass.sv -----
// cascaded third-order iir lowpass, top level with stream handshakes
// each input transaction runs four bit-serial passes in the shared engine, then the
// result is rounded into the output register; a new sample is accepted only after
// the previous result has been taken into the output register
// rst_n synchronous active low clears all histories; in_tready is high right after reset
module cascaded_third_order_iir_lowpass (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [c3iir_pkg::SAMPLE_W-1:0]  in_tdata,   // [15:0] sample_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [c3iir_pkg::SAMPLE_W-1:0]  out_tdata   // [15:0] sample_out
);
  import c3iir_pkg::*;

  logic                       go;
  logic                       seq_ready;
  logic                       res_valid;
  logic                       res_take;
  st_word_t                   y;

  logic signed [RND_W:0]      rnd_sum;
  logic signed [RND_W-1:0]    rnd_val;
  logic [RND_W-SAMPLE_W:0]    hi_bits;
  logic [SAMPLE_W-1:0]        sat_out;

  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_data_r, out_data_nxt;

  assign in_tready = seq_ready;
  assign go        = in_tvalid & seq_ready;

  c3iir_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .sample   (signed'(in_tdata)),
    .ready    (seq_ready),
    .res_valid(res_valid),
    .res_take (res_take),
    .y        (y)
  );

  // round half up at the fraction point, then saturate to the sample range
  always_comb begin
    rnd_sum = {y[STATE_W-1], y[STATE_W-1:FRAC_W-1]} + (RND_W+1)'(1);
    rnd_val = rnd_sum[RND_W:1];
    hi_bits = rnd_val[RND_W-1:SAMPLE_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      sat_out = rnd_val[SAMPLE_W-1:0];
    end else if (rnd_val[RND_W-1]) begin
      sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sat_out;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
